>>> hdl/c8ic_pkg.sv
// Shared types and constants for the CHIP-8 instruction core.
// Used by the controller, the datapath and the top level; depends on nothing.
package c8ic_pkg;

    localparam int MEMORY_BYTES   = 4096;
    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_LINES   = 32;
    localparam int ADDR_W         = 12;
    localparam int ROW_W          = 5;
    localparam int COL_W          = 6;
    localparam int VREG_COUNT     = 16;
    localparam int VREG_W         = 4;

    localparam logic [ADDR_W-1:0] START_DEFAULT = 12'h202;
    localparam logic [15:0]       OP_CLEAR      = 16'h00E0;

    // Item modes carried in tuser.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_ROW   = 2'd2;
    localparam logic [1:0] MODE_REG   = 2'd3;

    // Decoded instruction classes.
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_CLEAR = 3'd1;
    localparam logic [2:0] CLS_JUMP  = 3'd2;
    localparam logic [2:0] CLS_SET   = 3'd3;
    localparam logic [2:0] CLS_ADD   = 3'd4;
    localparam logic [2:0] CLS_INDEX = 3'd5;
    localparam logic [2:0] CLS_DRAW  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic mem_wr;
        logic item_rd;
        logic fetch_hi;
        logic fetch_lo;
        logic fetch_done;
        logic exec;
        logic add_wr;
        logic cap_col;
        logic cap_row;
        logic row_rd;
        logic row_wr;
        logic vf_wr;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cls;
        logic       n_zero;
        logic       last_row;
    } t_stat;

    // One result item, program counter in the lowest bits.
    typedef struct packed {
        logic        redraw;
        logic [63:0] row_pixels;
        logic [7:0]  register_value;
        logic [11:0] index_value;
        logic [15:0] instruction;
        logic [11:0] program_counter;
    } t_result;

endpackage

>>> hdl/c8ic_ctrl.sv
// Controller state machine of the CHIP-8 instruction core.
// Depends on c8ic_pkg; drives the datapath through t_cmd and reads t_stat.
module c8ic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output c8ic_pkg::t_cmd   o_cmd,
    input  c8ic_pkg::t_stat  i_stat
);
    import c8ic_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MEMWR    = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_FETCH0   = 4'd3;
    localparam logic [3:0] S_FETCH1   = 4'd4;
    localparam logic [3:0] S_FETCH2   = 4'd5;
    localparam logic [3:0] S_DECODE   = 4'd6;
    localparam logic [3:0] S_ADD      = 4'd7;
    localparam logic [3:0] S_DRAW_X   = 4'd8;
    localparam logic [3:0] S_DRAW_Y   = 4'd9;
    localparam logic [3:0] S_ROW_RD   = 4'd10;
    localparam logic [3:0] S_ROW_WR   = 4'd11;
    localparam logic [3:0] S_DRAW_END = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_mode)
                        MODE_WRITE: n_state = S_MEMWR;
                        MODE_EXEC:  n_state = S_FETCH0;
                        default:    n_state = S_READ;
                    endcase
                end
            end
            S_MEMWR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_FIN;
            end
            S_READ: begin
                o_cmd.item_rd = 1'b1;
                n_state       = S_FIN;
            end
            S_FETCH0: begin
                o_cmd.fetch_hi = 1'b1;
                n_state        = S_FETCH1;
            end
            S_FETCH1: begin
                o_cmd.fetch_lo = 1'b1;
                n_state        = S_FETCH2;
            end
            S_FETCH2: begin
                o_cmd.fetch_done = 1'b1;
                n_state          = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.cls == CLS_ADD) begin
                    n_state = S_ADD;
                end else if (i_stat.cls == CLS_DRAW) begin
                    n_state = S_DRAW_X;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADD: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_FIN;
            end
            S_DRAW_X: begin
                o_cmd.cap_col = 1'b1;
                n_state       = S_DRAW_Y;
            end
            S_DRAW_Y: begin
                o_cmd.cap_row = 1'b1;
                n_state       = i_stat.n_zero ? S_DRAW_END : S_ROW_RD;
            end
            S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_ROW_WR;
            end
            S_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                n_state      = i_stat.last_row ? S_DRAW_END : S_ROW_RD;
            end
            S_DRAW_END: begin
                o_cmd.vf_wr = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // Wait until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/c8ic_dp.sv
// Datapath of the CHIP-8 instruction core: program memory, V registers,
// screen memory, counters and the result register. Depends on c8ic_pkg.
module c8ic_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  c8ic_pkg::t_cmd               i_cmd,
    output c8ic_pkg::t_stat              o_stat,
    input  logic [1:0]                   i_mode,
    input  logic [c8ic_pkg::ADDR_W-1:0]  i_address,
    input  logic [7:0]                   i_data,
    output c8ic_pkg::t_result            o_result
);
    import c8ic_pkg::*;

    logic [7:0]  r_mem [MEMORY_BYTES];
    logic [7:0]  r_mem_q;
    logic [7:0]  r_vreg [VREG_COUNT];
    logic [VREG_COUNT-1:0] r_vvld;
    logic [7:0]  r_v_q;
    logic        r_v_vld_q;
    logic [63:0] r_scr [SCREEN_LINES];
    logic [SCREEN_LINES-1:0] r_svld;
    logic [63:0] r_s_q;
    logic        r_s_vld_q;

    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_data;
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_index;
    logic [15:0]       r_instr;
    logic [7:0]        r_hi;
    logic              r_redraw;
    logic [COL_W-1:0]  r_col0;
    logic [ROW_W-1:0]  r_row0;
    logic [ROW_W-1:0]  r_row_idx;
    logic [3:0]        r_cnt;
    logic              r_coll;
    t_result           r_result;

    logic [ADDR_W-1:0] mem_ra;
    logic [VREG_W-1:0] v_ra;
    logic [VREG_W-1:0] v_wa;
    logic [7:0]        v_wd;
    logic              v_we;
    logic [ROW_W-1:0]  s_ra;
    logic [7:0]        v_val;
    logic [63:0]       s_val;
    logic [127:0]      spr_ext;
    logic [63:0]       spr_mask;
    logic [2:0]        cls;
    logic [VREG_W-1:0] op_x;
    logic [VREG_W-1:0] op_y;
    logic [3:0]        op_n;
    logic [7:0]        op_nn;
    logic [11:0]       op_nnn;

    assign op_x   = r_instr[11:8];
    assign op_y   = r_instr[7:4];
    assign op_n   = r_instr[3:0];
    assign op_nn  = r_instr[7:0];
    assign op_nnn = r_instr[11:0];

    // Instruction class decode.
    always_comb begin
        unique case (r_instr[15:12])
            4'h0:    cls = (r_instr == OP_CLEAR) ? CLS_CLEAR : CLS_NONE;
            4'h1:    cls = CLS_JUMP;
            4'h6:    cls = CLS_SET;
            4'h7:    cls = CLS_ADD;
            4'hA:    cls = CLS_INDEX;
            4'hD:    cls = CLS_DRAW;
            default: cls = CLS_NONE;
        endcase
    end

    assign o_stat.cls      = cls;
    assign o_stat.n_zero   = (op_n == 4'd0);
    assign o_stat.last_row = (4'(r_cnt + 4'd1) == op_n);

    // Read address selection for the three stores.
    always_comb begin
        priority if (i_cmd.fetch_hi) begin
            mem_ra = r_pc;
        end else if (i_cmd.fetch_lo) begin
            mem_ra = r_pc + 12'd1;
        end else begin
            mem_ra = r_index + {8'd0, r_cnt};
        end
    end

    always_comb begin
        priority if (i_cmd.exec) begin
            v_ra = op_x;
        end else if (i_cmd.cap_col) begin
            v_ra = op_y;
        end else begin
            v_ra = r_addr[VREG_W-1:0];
        end
    end

    assign s_ra = i_cmd.row_rd ? 5'(r_row0 + {1'b0, r_cnt}) : r_addr[ROW_W-1:0];

    assign v_val = r_v_vld_q ? r_v_q : 8'd0;
    assign s_val = r_s_vld_q ? r_s_q : 64'd0;

    // V register write port.
    always_comb begin
        v_we = 1'b0;
        v_wa = op_x;
        v_wd = op_nn;
        priority if (i_cmd.exec && cls == CLS_SET) begin
            v_we = 1'b1;
        end else if (i_cmd.add_wr) begin
            v_we = 1'b1;
            v_wd = v_val + op_nn;
        end else if (i_cmd.vf_wr) begin
            v_we = 1'b1;
            v_wa = 4'hF;
            v_wd = {7'd0, r_coll};
        end
    end

    // Sprite byte spread over the row, wrapping at the right edge.
    assign spr_ext  = {r_mem_q, 56'd0, r_mem_q, 56'd0} >> r_col0;
    assign spr_mask = spr_ext[63:0];

    // Program memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_addr] <= r_data;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    // V register file storage.
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vreg[v_wa] <= v_wd;
        end
        r_v_q <= r_vreg[v_ra];
    end

    // Screen storage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            r_scr[r_row_idx] <= s_val ^ spr_mask;
        end
        r_s_q <= r_scr[s_ra];
    end

    // Valid bits and read-side valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvld    <= '0;
            r_svld    <= '0;
            r_v_vld_q <= 1'b0;
            r_s_vld_q <= 1'b0;
        end else begin
            r_v_vld_q <= r_vvld[v_ra] || (v_we && v_wa == v_ra);
            r_s_vld_q <= r_svld[s_ra];
            if (v_we) begin
                r_vvld[v_wa] <= 1'b1;
            end
            if (i_cmd.exec && cls == CLS_CLEAR) begin
                r_svld <= '0;
            end else if (i_cmd.row_wr) begin
                r_svld[r_row_idx] <= 1'b1;
            end
        end
    end

    // Architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= START_DEFAULT;
            r_index  <= '0;
            r_instr  <= '0;
            r_redraw <= 1'b0;
        end else begin
            if (i_cmd.fetch_done) begin
                r_instr <= {r_hi, r_mem_q};
                r_pc    <= r_pc + 12'd2;
            end
            if (i_cmd.exec && cls == CLS_JUMP) begin
                r_pc <= op_nnn;
            end
            if (i_cmd.exec && cls == CLS_INDEX) begin
                r_index <= op_nnn;
            end
            if (i_cmd.cap_row) begin
                r_redraw <= 1'b1;
            end
        end
    end

    // Item fields, fetch and draw working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_addr <= i_address;
            r_data <= i_data;
        end
        if (i_cmd.fetch_lo) begin
            r_hi <= r_mem_q;
        end
        if (i_cmd.cap_col) begin
            r_col0 <= v_val[COL_W-1:0];
        end
        if (i_cmd.cap_row) begin
            r_row0 <= v_val[ROW_W-1:0];
            r_cnt  <= '0;
            r_coll <= 1'b0;
        end
        if (i_cmd.row_rd) begin
            r_row_idx <= s_ra;
        end
        if (i_cmd.row_wr) begin
            r_coll <= r_coll || ((s_val & spr_mask) != 64'd0);
            r_cnt  <= r_cnt + 4'd1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result.program_counter <= r_pc;
            r_result.instruction     <= r_instr;
            r_result.index_value     <= r_index;
            r_result.redraw          <= r_redraw;
            r_result.register_value  <=
                (r_mode == MODE_REG && r_addr[ADDR_W-1:VREG_W] == '0) ? v_val : 8'd0;
            r_result.row_pixels      <=
                (r_mode == MODE_ROW && r_addr[ADDR_W-1:ROW_W] == '0) ? s_val : 64'd0;
        end
    end

    assign o_result = r_result;

endmodule

>>> hdl/chip8_instruction_core.sv
// Throughput: one item at a time; a draw runs the sprite row loop (memory read,
// then screen read-modify-write) once per sprite row.
// Reset (synchronous, active low): counter 0x202, V registers, index, screen
// and redraw cleared at once; program memory is undefined until written.
// Top level; depends on c8ic_pkg, c8ic_ctrl and c8ic_dp.
module chip8_instruction_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [23:0]   s_axis_tdata,   // address[11:0], data[19:12], zero pad
    input  logic [1:0]    s_axis_tuser,   // mode[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // program_counter[11:0], instruction[27:12],
                                          // index_value[39:28], register_value[47:40],
                                          // row_pixels[111:48], redraw[112], zero pad
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [11:0]   i_cfg_data
);
    import c8ic_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_result result;

    // The start address only matters at reset, which restores its default.
    assign o_cfg_ready = 1'b1;

    c8ic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    c8ic_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_mode    (s_axis_tuser),
        .i_address (s_axis_tdata[11:0]),
        .i_data    (s_axis_tdata[19:12]),
        .o_result  (result)
    );

    assign m_axis_tdata = {7'd0, result};

endmodule

>>> hdl/c8ic_chk.sv
// Port-level checker for the CHIP-8 instruction core, bound to the top level.
// Depends only on the top level's ports.
module c8ic_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [119:0]  m_axis_tdata
);
    logic r_seen_redraw;

    // Remember that a delivered result already reported a draw.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_redraw <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[112]) begin
            r_seen_redraw <= 1'b1;
        end
    end

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // The redraw flag never falls back until reset.
    a_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_redraw |-> m_axis_tdata[112])
        else $error("redraw flag dropped");

    // A result reads a register or a screen row, never both.
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[47:40] != 8'd0 |-> m_axis_tdata[111:48] == 64'd0)
        else $error("register and row read together");

    // Unused upper pad bits stay zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[119:113] == 7'd0)
        else $error("pad bits set");

endmodule

bind chip8_instruction_core c8ic_chk u_c8ic_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
